// File: sv/vna_pkg.sv
`timescale 1ns / 1ps

package vna_pkg;

  localparam int SUM_W   = 43;  // accumulated face normal component
  localparam int WIN_W   = 11;
  localparam int VC_W    = 13;
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 1;
  localparam int NORM_W  = 16;
  localparam int STAT_W  = 2;
  localparam int MAG_LIM = 30;  // magnitudes are scaled below 2^MAG_LIM
  localparam int SQ_W    = 64;
  localparam int LEN_W   = 32;
  localparam int QUO_W   = 16;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_VCOUNT = 1'd1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEGEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RST = 11'd100;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic start;
    sum_t sx;
    sum_t sy;
    sum_t sz;
  } norm_req_t;

  typedef struct packed {
    logic                     valid;
    logic                     degen;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } norm_rsp_t;

endpackage

// File: sv/vna_vertex_mem.sv
`timescale 1ns / 1ps

module vna_vertex_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/vna_normalize.sv
`timescale 1ns / 1ps

module vna_normalize (
  input  logic              clk,
  input  logic              rst_n,
  input  vna_pkg::norm_req_t req,
  output vna_pkg::norm_rsp_t rsp
);
  import vna_pkg::*;

  localparam int NUM_W = MAG_LIM + QUO_W + 1;

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV, N_OUT} nstate_t;

  nstate_t                   state_r;
  logic [SUM_W-1:0]          mag_r [3];
  logic [2:0]                neg_r;
  logic [3:0]                cnt_r;
  logic [1:0]                comp_r;
  logic [2*MAG_LIM-1:0]      prod_r;
  logic [SQ_W-1:0]           acc_r;
  logic [SQ_W-1:0]           root_r;
  logic [SQ_W-1:0]           bit_r;
  logic [LEN_W:0]            den_r;
  logic [LEN_W:0]            rem_r;
  logic [QUO_W-1:0]          num_r;
  logic [QUO_W-1:0]          quo_r;
  logic signed [NORM_W-1:0]  nrm_r [3];
  norm_rsp_t                 rsp_r;

  logic                      over;
  logic [1:0]                sel;
  logic [MAG_LIM-1:0]        msel;
  logic [2*MAG_LIM-1:0]      sq;
  logic [SQ_W-1:0]           trial_sq;
  logic                      ge_sq;
  logic [LEN_W-1:0]          lenv;
  logic [NUM_W-1:0]          numer;
  logic [LEN_W+1:0]          trial_d;
  logic                      ge_d;
  logic [QUO_W-1:0]          qf;
  logic [NORM_W-1:0]         rs;
  logic signed [NORM_W-1:0]  nres;

  always_comb begin
    over = (|mag_r[0][SUM_W-1:MAG_LIM]) | (|mag_r[1][SUM_W-1:MAG_LIM]) |
           (|mag_r[2][SUM_W-1:MAG_LIM]);
    sel = (state_r == N_SQ) ? cnt_r[1:0] : comp_r;
    case (sel)
      2'd0:    msel = mag_r[0][MAG_LIM-1:0];
      2'd1:    msel = mag_r[1][MAG_LIM-1:0];
      default: msel = mag_r[2][MAG_LIM-1:0];
    endcase
    sq       = msel * msel;
    trial_sq = root_r + bit_r;
    ge_sq    = acc_r >= trial_sq;
    lenv     = (root_r[LEN_W-1:0] == '0) ? LEN_W'(1) : root_r[LEN_W-1:0];
    numer    = {1'b0, msel, {QUO_W{1'b0}}} + NUM_W'(lenv);
    trial_d  = {rem_r, num_r[QUO_W-1]};
    ge_d     = trial_d >= {1'b0, den_r};
    qf       = {quo_r[QUO_W-2:0], ge_d};
    rs       = qf[QUO_W-1] ? {1'b0, {(NORM_W-1){1'b1}}} : qf;
    nres     = neg_r[comp_r] ? -$signed(rs) : $signed(rs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= N_IDLE;
      rsp_r.valid <= 1'b0;
    end else begin
      rsp_r.valid <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            neg_r    <= {req.sz[SUM_W-1], req.sy[SUM_W-1], req.sx[SUM_W-1]};
            mag_r[0] <= req.sx[SUM_W-1] ? SUM_W'(-req.sx) : SUM_W'(req.sx);
            mag_r[1] <= req.sy[SUM_W-1] ? SUM_W'(-req.sy) : SUM_W'(req.sy);
            mag_r[2] <= req.sz[SUM_W-1] ? SUM_W'(-req.sz) : SUM_W'(req.sz);
            if (req.sx == '0 && req.sy == '0 && req.sz == '0) begin
              rsp_r.valid <= 1'b1;
              rsp_r.degen <= 1'b1;
              rsp_r.nx    <= '0;
              rsp_r.ny    <= '0;
              rsp_r.nz    <= '0;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (over) begin
            mag_r[0] <= mag_r[0] >> 1;
            mag_r[1] <= mag_r[1] >> 1;
            mag_r[2] <= mag_r[2] >> 1;
          end else begin
            cnt_r   <= '0;
            prod_r  <= '0;
            acc_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          // each square is registered, then accumulated in the following cycle
          prod_r <= (cnt_r[1:0] == 2'd3) ? '0 : sq;
          acc_r  <= acc_r + SQ_W'(prod_r);
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r[1:0] == 2'd3) begin
            root_r  <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 2);
            state_r <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (ge_sq) begin
            acc_r  <= acc_r - trial_sq;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            comp_r  <= 2'd0;
            state_r <= N_DSET;
          end
        end
        N_DSET: begin
          den_r   <= {lenv, 1'b0};
          rem_r   <= (LEN_W+1)'(numer[NUM_W-1:QUO_W]);
          num_r   <= numer[QUO_W-1:0];
          quo_r   <= '0;
          cnt_r   <= 4'(QUO_W - 1);
          state_r <= N_DIV;
        end
        N_DIV: begin
          rem_r <= ge_d ? (LEN_W+1)'(trial_d - {1'b0, den_r}) : (LEN_W+1)'(trial_d);
          num_r <= num_r << 1;
          quo_r <= qf;
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            case (comp_r)
              2'd0:    nrm_r[0] <= nres;
              2'd1:    nrm_r[1] <= nres;
              default: nrm_r[2] <= nres;
            endcase
            if (comp_r == 2'd2) begin
              state_r <= N_OUT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= N_DSET;
            end
          end
        end
        N_OUT: begin
          rsp_r.valid <= 1'b1;
          rsp_r.degen <= 1'b0;
          rsp_r.nx    <= nrm_r[0];
          rsp_r.ny    <= nrm_r[1];
          rsp_r.nz    <= nrm_r[2];
          state_r     <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

// File: sv/vertex_normal_accumulate_unit.sv
`timescale 1ns / 1ps

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+--------------------------
// input     | in_mode in_index in_coord_x/y/z         | start && !busy
// result    | out_normal_x/y/z out_status             | out_valid, one cycle
// config    | cfg_index cfg_data                      | cfg_we, no wait
//
// A store does not raise busy. A query beyond the count raises out_valid
// after the S_DIV and S_CHK states. Otherwise the single read port of the
// vertex memory takes each scanned triangle through S_TEST, S_R1, S_R2, S_MUL
// and S_ACC; then the normalizer shifts the sums into range, squares and
// accumulates them, takes a square root and runs three divides.
// Synchronous active-low reset; the vertex memory is not cleared. Results
// cannot be stalled.

module vertex_normal_accumulate_unit #(
  parameter int MAX_VERTICES = 4096,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_mode,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_index,
  input  logic signed [COORD_BITS-1:0]          in_coord_x,
  input  logic signed [COORD_BITS-1:0]          in_coord_y,
  input  logic signed [COORD_BITS-1:0]          in_coord_z,
  output logic                                  out_valid,
  output logic signed [vna_pkg::NORM_W-1:0]     out_normal_x,
  output logic signed [vna_pkg::NORM_W-1:0]     out_normal_y,
  output logic signed [vna_pkg::NORM_W-1:0]     out_normal_z,
  output logic [vna_pkg::STAT_W-1:0]            out_status,
  input  logic                                  cfg_we,
  input  logic [vna_pkg::CFG_IW-1:0]            cfg_index,
  input  logic [vna_pkg::CFG_DW-1:0]            cfg_data
);
  import vna_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CLG   = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W = (VC_W > CLG) ? VC_W : CLG;
  localparam int TW    = CNT_W + 1;
  localparam int DS    = CNT_W + 1 + ((CNT_W + 1) % 2);
  localparam int DM    = ((1 << DS) + 2) / 3;
  localparam int DPW   = CNT_W + DS;
  localparam int VW    = 3 * COORD_BITS;
  localparam int DFW   = COORD_BITS + 1;
  localparam int PW    = 2 * DFW;
  localparam int CW    = PW + 1;
  localparam int AW    = ((CW > SUM_W) ? CW : SUM_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CHK, S_QCAP, S_TEST, S_R1, S_R2, S_MUL, S_ACC, S_NORM
  } state_t;

  state_t               state_r;
  logic                 busy_r;
  logic [WIN_W-1:0]     window_r;
  logic [VC_W-1:0]      vcount_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     dn_i_r, dn_c_r, q_i_r, q_c_r;
  logic [TW-1:0]        tri_r, end_r;
  logic [IDX_W-1:0]     j_r;
  logic [VW-1:0]        qv_r, v0_r, v1_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic                 hit_r;
  sum_t                 sum_r [3];
  logic                 nstart_r;
  logic                 out_valid_r;
  logic signed [NORM_W-1:0] onx_r, ony_r, onz_r;
  logic [STAT_W-1:0]    ost_r;

  logic                 accept;
  logic                 mem_we;
  logic [IDX_W-1:0]     raddr;
  logic [VW-1:0]        rdata;
  logic [CNT_W-1:0]     vc_clamp;
  logic [TW-1:0]        idx_tri, cnt_tri, win_t, start_tri, hi_tri;
  logic signed [COORD_BITS-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
  logic signed [DFW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf;
  logic                 hit;
  sum_t                 sum_nxt [3];
  norm_req_t            nreq;
  norm_rsp_t            nrsp;

  // floor(v / 3) by a rounded-up reciprocal, exact for v below 2^(DS-1)
  function automatic logic [CNT_W-1:0] div3(input logic [CNT_W-1:0] v);
    logic [DPW-1:0] p;
    p = DPW'(v) * DPW'(DM);
    return p[DPW-1:DS];
  endfunction

  function automatic sum_t sat_add(input sum_t a, input logic signed [CW-1:0] b);
    logic signed [AW-1:0] s;
    s = AW'(a) + AW'(b);
    if (s[AW-1:SUM_W-1] == '0 || s[AW-1:SUM_W-1] == '1) return s[SUM_W-1:0];
    else if (s[AW-1]) return {1'b1, {(SUM_W-1){1'b0}}};
    else return {1'b0, {(SUM_W-1){1'b1}}};
  endfunction

  assign accept = start && !busy_r;
  assign mem_we = accept && (in_mode == MODE_STORE) &&
                  ({1'b0, in_index} < (IDX_W+1)'(MAX_VERTICES));

  vna_vertex_mem #(.DEPTH(MAX_VERTICES), .AW(IDX_W), .DW(VW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_index),
    .wdata ({in_coord_x, in_coord_y, in_coord_z}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (state_r)
      S_CHK:   raddr = idx_r;
      S_R1:    raddr = IDX_W'(j_r + IDX_W'(1));
      S_R2:    raddr = IDX_W'(j_r + IDX_W'(2));
      default: raddr = j_r;
    endcase
  end

  always_comb begin
    vc_clamp = (CNT_W'(vcount_r) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(vcount_r);
    idx_tri   = TW'(q_i_r);
    cnt_tri   = TW'(q_c_r);
    win_t     = TW'(window_r);
    start_tri = (idx_tri >= win_t) ? idx_tri - win_t : '0;
    hi_tri    = idx_tri + win_t;
  end

  // triangle geometry; the third vertex comes straight off the memory port
  always_comb begin
    x0 = v0_r[VW-1 -: COORD_BITS];
    y0 = v0_r[2*COORD_BITS-1 -: COORD_BITS];
    z0 = v0_r[COORD_BITS-1:0];
    x1 = v1_r[VW-1 -: COORD_BITS];
    y1 = v1_r[2*COORD_BITS-1 -: COORD_BITS];
    z1 = v1_r[COORD_BITS-1:0];
    x2 = rdata[VW-1 -: COORD_BITS];
    y2 = rdata[2*COORD_BITS-1 -: COORD_BITS];
    z2 = rdata[COORD_BITS-1:0];
    ux = DFW'(x0) - DFW'(x1);
    uy = DFW'(y0) - DFW'(y1);
    uz = DFW'(z0) - DFW'(z1);
    vx = DFW'(x0) - DFW'(x2);
    vy = DFW'(y0) - DFW'(y2);
    vz = DFW'(z0) - DFW'(z2);
    pa = uy * vz;
    pb = uz * vy;
    pc = uz * vx;
    pd = ux * vz;
    pe = ux * vy;
    pf = uy * vx;
    hit = (qv_r == v0_r) || (qv_r == v1_r) || (qv_r == rdata);
    sum_nxt[0] = sat_add(sum_r[0], CW'(pa_r) - CW'(pb_r));
    sum_nxt[1] = sat_add(sum_r[1], CW'(pc_r) - CW'(pd_r));
    sum_nxt[2] = sat_add(sum_r[2], CW'(pe_r) - CW'(pf_r));
  end

  assign nreq.start = nstart_r;
  assign nreq.sx    = sum_r[0];
  assign nreq.sy    = sum_r[1];
  assign nreq.sz    = sum_r[2];

  vna_normalize u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      window_r    <= WINDOW_RST;
      vcount_r    <= '0;
      nstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
    end else begin
      nstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
          CFG_VCOUNT: vcount_r <= cfg_data[VC_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_mode == MODE_QUERY) begin
            busy_r   <= 1'b1;
            idx_r    <= in_index;
            dn_i_r   <= CNT_W'(in_index);
            dn_c_r   <= vc_clamp;
            sum_r[0] <= '0;
            sum_r[1] <= '0;
            sum_r[2] <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          // triangle numbers of the index and of the count
          q_i_r   <= div3(dn_i_r);
          q_c_r   <= div3(dn_c_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (idx_tri >= cnt_tri) begin
            out_valid_r <= 1'b1;
            onx_r       <= '0;
            ony_r       <= '0;
            onz_r       <= '0;
            ost_r       <= ST_RANGE;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            tri_r   <= start_tri;
            end_r   <= (hi_tri > cnt_tri) ? cnt_tri : hi_tri;
            j_r     <= IDX_W'((TW+2)'(start_tri) + ((TW+2)'(start_tri) << 1));
            state_r <= S_QCAP;
          end
        end
        S_QCAP: begin
          qv_r    <= rdata;
          state_r <= S_TEST;
        end
        S_TEST: begin
          if (tri_r >= end_r) begin
            nstart_r <= 1'b1;
            state_r  <= S_NORM;
          end else begin
            state_r <= S_R1;
          end
        end
        S_R1: begin
          v0_r    <= rdata;
          state_r <= S_R2;
        end
        S_R2: begin
          v1_r    <= rdata;
          state_r <= S_MUL;
        end
        S_MUL: begin
          pa_r    <= pa;
          pb_r    <= pb;
          pc_r    <= pc;
          pd_r    <= pd;
          pe_r    <= pe;
          pf_r    <= pf;
          hit_r   <= hit;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (hit_r) begin
            sum_r[0] <= sum_nxt[0];
            sum_r[1] <= sum_nxt[1];
            sum_r[2] <= sum_nxt[2];
          end
          tri_r   <= tri_r + TW'(1);
          j_r     <= IDX_W'(j_r + IDX_W'(3));
          state_r <= S_TEST;
        end
        S_NORM: begin
          if (nrsp.valid) begin
            out_valid_r <= 1'b1;
            onx_r       <= nrsp.nx;
            ony_r       <= nrsp.ny;
            onz_r       <= nrsp.nz;
            ost_r       <= nrsp.degen ? ST_DEGEN : ST_OK;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_normal_x = onx_r;
  assign out_normal_y = ony_r;
  assign out_normal_z = onz_r;
  assign out_status   = ost_r;

endmodule

// File: sv/vna_checker.sv
`timescale 1ns / 1ps

module vna_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_mode,
  input logic                               out_valid,
  input logic signed [vna_pkg::NORM_W-1:0]  out_normal_x,
  input logic signed [vna_pkg::NORM_W-1:0]  out_normal_y,
  input logic signed [vna_pkg::NORM_W-1:0]  out_normal_z,
  input logic [vna_pkg::STAT_W-1:0]         out_status
);
  import vna_pkg::*;

  // a result beat ends the query
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_QUERY) |=> busy)
    else $error("query accepted but not busy");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_STORE) |=> !out_valid)
    else $error("store produced a result");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result beats");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("nonzero normal on failed query");

endmodule

bind vertex_normal_accumulate_unit vna_checker u_vna_checker (.*);

// File: tb/vertex_normal_accumulate_unit_test.sv
`timescale 1ns / 1ps

class normal_scoreboard;
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         st;
  } normal_t;

  int       window_tri;
  int       vert_count;
  shortint  vx[4096];
  shortint  vy[4096];
  shortint  vz[4096];
  normal_t  expected_normals[$];
  int       mismatches;
  int       results_seen;
  int       n_ok;
  int       n_degen;
  int       n_range;

  function new();
    window_tri = 100;
    vert_count = 0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void write_reg(logic [vna_pkg::CFG_IW-1:0] idx, int val);
    if (idx == vna_pkg::CFG_WINDOW) window_tri = val & 'h7ff;
    else vert_count = val & 'h1fff;
  endfunction

  function int rounded_count();
    int c;
    c = (vert_count < 4096) ? vert_count : 4096;
    return c - c % 3;
  endfunction

  function bit same_vertex(int a, int b);
    return vx[a] == vx[b] && vy[a] == vy[b] && vz[a] == vz[b];
  endfunction

  function longint sat_sum(longint a, longint b);
    longint s;
    longint hi;
    hi = (longint'(1) <<< 42) - 1;
    s = a + b;
    if (s > hi) return hi;
    if (s < -hi - 1) return -hi - 1;
    return s;
  endfunction

  function longint unsigned int_sqrt(longint unsigned q);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function void note_item(logic mode, int idx, shortint x, shortint y, shortint z);
    normal_t e;
    int cnt, base, lo, hi, j, k;
    longint acc[3];
    longint ux, uy, uz, wx, wy, wz;
    longint unsigned m[3];
    longint unsigned len, r;
    if (mode == vna_pkg::MODE_STORE) begin
      vx[idx] = x;
      vy[idx] = y;
      vz[idx] = z;
      return;
    end
    e = '{16'sd0, 16'sd0, 16'sd0, vna_pkg::ST_OK};
    cnt = rounded_count();
    if (idx >= cnt) begin
      e.st = vna_pkg::ST_RANGE;
      n_range++;
      expected_normals.insert(expected_normals.size(), e);
      return;
    end
    acc = '{0, 0, 0};
    base = idx - idx % 3;
    lo = (base >= 3 * window_tri) ? base - 3 * window_tri : 0;
    hi = base + 3 * window_tri;
    if (hi > cnt) hi = cnt;
    for (j = lo; j < hi; j += 3) begin
      if (same_vertex(idx, j) || same_vertex(idx, j + 1) || same_vertex(idx, j + 2)) begin
        ux = longint'(vx[j]) - vx[j+1];
        uy = longint'(vy[j]) - vy[j+1];
        uz = longint'(vz[j]) - vz[j+1];
        wx = longint'(vx[j]) - vx[j+2];
        wy = longint'(vy[j]) - vy[j+2];
        wz = longint'(vz[j]) - vz[j+2];
        acc[0] = sat_sum(acc[0], uy * wz - uz * wy);
        acc[1] = sat_sum(acc[1], uz * wx - ux * wz);
        acc[2] = sat_sum(acc[2], ux * wy - uy * wx);
      end
    end
    for (k = 0; k < 3; k++) m[k] = (acc[k] < 0) ? -acc[k] : acc[k];
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
      e.st = vna_pkg::ST_DEGEN;
      n_degen++;
      expected_normals.insert(expected_normals.size(), e);
      return;
    end
    while ((m[0] >> 30) != 0 || (m[1] >> 30) != 0 || (m[2] >> 30) != 0)
      for (k = 0; k < 3; k++) m[k] >>= 1;
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (len == 0) len = 1;
    for (k = 0; k < 3; k++) begin
      r = (m[k] * 65536 + len) / (2 * len);
      if (r > 32767) r = 32767;
      if (acc[k] < 0) r = -r;
      if (k == 0) e.nx = r[15:0];
      else if (k == 1) e.ny = r[15:0];
      else e.nz = r[15:0];
    end
    n_ok++;
    expected_normals.insert(expected_normals.size(), e);
  endfunction

  function void check_result(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz, logic [1:0] st);
    normal_t e;
    results_seen++;
    if (expected_normals.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: %0d %0d %0d status %0d",
                                     nx, ny, nz, st);
      return;
    end
    e = expected_normals.pop_front();
    if (e.nx !== nx || e.ny !== ny || e.nz !== nz || e.st !== st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("normal mismatch: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                 e.nx, e.ny, e.nz, e.st, nx, ny, nz, st);
    end
  endfunction
endclass

module vertex_normal_accumulate_unit_test;
  import vna_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_mode;
  logic [11:0]                in_index;
  logic signed [15:0]         in_coord_x;
  logic signed [15:0]         in_coord_y;
  logic signed [15:0]         in_coord_z;
  logic                       out_valid;
  logic signed [NORM_W-1:0]   out_normal_x;
  logic signed [NORM_W-1:0]   out_normal_y;
  logic signed [NORM_W-1:0]   out_normal_z;
  logic [STAT_W-1:0]          out_status;
  logic                       cfg_we;
  logic [CFG_IW-1:0]          cfg_index;
  logic [CFG_DW-1:0]          cfg_data;

  normal_scoreboard sb;
  int filled;        // vertices 0..filled-1 have been written
  int stores_sent;
  int queries_sent;
  shortint pool_x[6];
  shortint pool_y[6];
  shortint pool_z[6];

  vertex_normal_accumulate_unit DUT (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_normal_x, out_normal_y, out_normal_z, out_status);
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(logic mode, int idx, int x, int y, int z);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode;
    in_index = 12'(idx);
    in_coord_x = 16'(x);
    in_coord_y = 16'(y);
    in_coord_z = 16'(z);
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(mode, idx, shortint'(x), shortint'(y), shortint'(z));
    if (mode == MODE_STORE) stores_sent++;
    else queries_sent++;
    @(negedge clk);
  endtask

  // let every outstanding query come back before touching config
  task automatic drain();
    start = 1'b0;
    while (sb.expected_normals.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DW'(val);
    @(negedge clk);
    sb.write_reg(idx, val);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  function automatic shortint pick_coord(int kind);
    case (kind)
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      1: return shortint'($urandom_range(0, 65535));
      default: return shortint'(int'($urandom_range(0, 100)) - 50);
    endcase
  endfunction

  // in-range queries must only scan vertices that were written
  task automatic random_query();
    int cnt, idx, base, hi;
    bit ok;
    cnt = sb.rounded_count();
    idx = (cnt > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, cnt - 1)
                                                 : $urandom_range(0, 4095);
    base = idx - idx % 3;
    hi = base + 3 * sb.window_tri;
    if (hi > cnt) hi = cnt;
    ok = idx >= cnt || (idx < filled && hi <= filled);
    if (!ok) idx = (cnt < 4096) ? $urandom_range(cnt, 4095) : 0;
    send_item(MODE_QUERY, idx, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
  endtask

  initial begin
    int i, p, n, kind, w, vc;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_STORE;
    in_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    filled = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty mesh, shared corner, collinear face, window extremes
    send_item(MODE_QUERY, 0, 0, 0, 0);
    send_item(MODE_QUERY, 4095, -1, -1, -1);
    send_item(MODE_STORE, 0, -32768, -32768, -32768);
    send_item(MODE_STORE, 1, 32767, -32768, -32768);
    send_item(MODE_STORE, 2, -32768, 32767, -32768);
    send_item(MODE_STORE, 3, -32768, -32768, -32768);
    send_item(MODE_STORE, 4, -32768, 32767, -32768);
    send_item(MODE_STORE, 5, -32768, -32768, 32767);
    send_item(MODE_STORE, 6, 5, 5, 5);
    send_item(MODE_STORE, 7, 5, 5, 5);
    send_item(MODE_STORE, 8, 9, -7, 3);
    filled = 9;
    drain();
    write_reg(CFG_VCOUNT, 9);
    send_item(MODE_QUERY, 0, 0, 0, 0);
    send_item(MODE_QUERY, 4, 0, 0, 0);
    send_item(MODE_QUERY, 5, 0, 0, 0);
    send_item(MODE_QUERY, 8, 0, 0, 0);
    drain();
    write_reg(CFG_VCOUNT, 10);
    send_item(MODE_QUERY, 9, 0, 0, 0);
    drain();
    write_reg(CFG_WINDOW, 0);
    send_item(MODE_QUERY, 0, 0, 0, 0);
    drain();
    write_reg(CFG_WINDOW, 1365);
    send_item(MODE_QUERY, 3, 0, 0, 0);

    // 100 identical large faces around one corner drive the sums far past 2^30
    drain();
    for (i = 0; i < 300; i += 3) begin
      send_item(MODE_STORE, i, -32768, 32767, -32768);
      send_item(MODE_STORE, i + 1, 32767, -32768, 32767);
      send_item(MODE_STORE, i + 2, 32767, 32767, -32768);
    end
    filled = 300;
    drain();
    write_reg(CFG_VCOUNT, 300);
    for (i = 0; i < 4; i++) send_item(MODE_QUERY, $urandom_range(0, 299), 0, 0, 0);

    while (stores_sent + queries_sent < 850) begin
      drain();
      p = ($urandom_range(0, 15) == 0) ? 3 * $urandom_range(60, 120)
                                      : 3 * $urandom_range(1, 60);
      kind = $urandom_range(0, 2);
      for (i = 0; i < 6; i++) begin
        pool_x[i] = pick_coord(kind);
        pool_y[i] = pick_coord(kind);
        pool_z[i] = pick_coord(kind);
      end
      for (i = 0; i < p; i++) begin
        n = $urandom_range(0, 5);
        if ($urandom_range(0, 19) == 0)
          send_item(MODE_STORE, i, pick_coord(1), pick_coord(1), pick_coord(1));
        else
          send_item(MODE_STORE, i, pool_x[n], pool_y[n], pool_z[n]);
      end
      if (filled < p) filled = p;
      // stray store far up; it lands beyond anything scanned as unwritten
      if ($urandom_range(0, 3) == 0)
        send_item(MODE_STORE, $urandom_range(filled, 4095), pick_coord(1), pick_coord(1),
                  pick_coord(1));
      drain();
      case ($urandom_range(0, 5))
        0: vc = p;
        1: vc = p + 1;
        2: vc = p + 2;
        3: vc = $urandom_range(0, p);
        4: vc = 4096;
        default: vc = 8191;
      endcase
      if (vc > filled) w = $urandom_range(0, 2);
      else begin
        case ($urandom_range(0, 4))
          0: w = 0;
          1: w = 1365;
          2: w = $urandom_range(1, 1365);
          default: w = $urandom_range(1, 8);
        endcase
      end
      write_reg(CFG_WINDOW, w);
      write_reg(CFG_VCOUNT, vc);
      n = $urandom_range(5, 25);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0 && p > 0) begin
          kind = $urandom_range(0, 5);
          send_item(MODE_STORE, $urandom_range(0, p - 1), pool_x[kind], pool_y[kind],
                    pool_z[kind]);
        end else begin
          random_query();
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d stores and %0d queries: %0d unit normals, %0d degenerate,",
             stores_sent, queries_sent, sb.n_ok, sb.n_degen);
    $display("%0d out of range; %0d result beats checked, %0d mismatches",
             sb.n_range, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_normals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
